@@ sv/gdo_pkg.sv @@
// gdo_pkg: shared types, constants and calendar helpers for gregorian_date_offset.
// No dependencies; every other file of the block but gdo_out_if refers to it by scoped names.
package gdo_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int SUM_BITS    = OFFSET_BITS + 6;
    localparam int STEP_BITS   = 4;
    localparam int ACC_BITS    = 12;

    localparam logic [13:0] BASE_YEAR = 14'd1601;
    localparam logic [13:0] LAST_YEAR = 14'd9999;

    localparam logic [STEP_BITS-1:0] REDUCE_TOP = 4'd5;
    localparam logic [STEP_BITS-1:0] MOD7_TOP   = 4'd8;

    typedef logic [1:0] t_status;
    localparam t_status STATUS_OK       = 2'd0;
    localparam t_status STATUS_BAD_DATE = 2'd1;
    localparam t_status STATUS_RANGE    = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_REDUCE,
        OP_MARK_BAD,
        OP_MARK_RANGE,
        OP_WALK,
        OP_WDAY,
        OP_MOD7,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [STEP_BITS-1:0] step;
    } t_cmd;

    typedef struct packed {
        logic bad_date;
        logic fwd_high;
        logic walk_done;
        logic walk_fail;
        logic year_high;
        logic out_busy;
    } t_stat;

    // leap test from year mod 400
    function automatic logic is_leap(input logic [8:0] yrem);
        is_leap = (yrem[1:0] == 2'd0) && (yrem != 9'd100) && (yrem != 9'd200)
                  && (yrem != 9'd300);
    endfunction

    function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
        case (m) inside
            4'd2:                    days_in_month = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: days_in_month = 5'd30;
            default:                 days_in_month = 5'd31;
        endcase
    endfunction

    // 23*m/9
    function automatic logic [4:0] month_term(input logic [3:0] m);
        case (m)
            4'd1:    month_term = 5'd2;
            4'd2:    month_term = 5'd5;
            4'd3:    month_term = 5'd7;
            4'd4:    month_term = 5'd10;
            4'd5:    month_term = 5'd12;
            4'd6:    month_term = 5'd15;
            4'd7:    month_term = 5'd17;
            4'd8:    month_term = 5'd20;
            4'd9:    month_term = 5'd23;
            4'd10:   month_term = 5'd25;
            4'd11:   month_term = 5'd28;
            4'd12:   month_term = 5'd30;
            default: month_term = 5'd0;
        endcase
    endfunction

endpackage

@@ sv/gdo_in_if.sv @@
// gdo_in_if: input channel (start date and day offset) with valid/ready.
// Depends on gdo_pkg for the offset width.
interface gdo_in_if;
    logic                                valid;
    logic                                ready;
    logic [4:0]                          in_day;
    logic [3:0]                          in_month;
    logic [13:0]                         in_year;
    logic signed [gdo_pkg::OFFSET_BITS-1:0] day_offset;

    modport source (output valid, output in_day, output in_month, output in_year,
                    output day_offset, input ready);
    modport sink   (input valid, input in_day, input in_month, input in_year,
                    input day_offset, output ready);
endinterface

@@ sv/gdo_out_if.sv @@
// gdo_out_if: result channel (moved date, weekday, status) with valid/ready.
// No dependencies.
interface gdo_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [13:0] out_year;
    logic [2:0]  weekday;
    logic [1:0]  status;

    modport source (output valid, output out_day, output out_month, output out_year,
                    output weekday, output status, input ready);
    modport sink   (input valid, input out_day, input out_month, input out_year,
                    input weekday, input status, output ready);
endinterface

@@ sv/gregorian_date_offset.sv @@
// gregorian_date_offset: top level, moves a Gregorian date by a signed day count.
// Depends on gdo_pkg, gdo_in_if, gdo_out_if, gdo_ctrl and gdo_datapath.
//
//   channel  dir  handshake        fields
//   i_in     in   valid / ready    in_day, in_month, in_year, day_offset
//   o_out    out  valid / ready    out_day, out_month, out_year, weekday, status
//
// One beat at a time: run time is set by the month-stride walk (one month per
// cycle), plus the year mod 400 and mod 7 reductions; invalid dates skip both
// the walk and the weekday reduction.
// Synchronous active-low reset clears the sequencer and the output valid.
// The output register frees the core: a new beat is taken while a result waits.
module gregorian_date_offset (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gdo_in_if.sink     i_in,
    gdo_out_if.source  o_out
);
    gdo_pkg::t_cmd  w_cmd;
    gdo_pkg::t_stat w_stat;
    logic           w_in_ready;

    gdo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    gdo_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_day        (i_in.in_day),
        .i_month      (i_in.in_month),
        .i_year       (i_in.in_year),
        .i_day_offset (i_in.day_offset),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_day        (o_out.out_day),
        .o_month      (o_out.out_month),
        .o_year       (o_out.out_year),
        .o_weekday    (o_out.weekday),
        .o_status     (o_out.status)
    );

    assign i_in.ready = w_in_ready;

endmodule

@@ sv/gdo_datapath.sv @@
// gdo_datapath: date registers, year mod 400 reduction, month-stride walk,
// weekday mod 7 reduction and output register. Depends on gdo_pkg.
module gdo_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  gdo_pkg::t_cmd                     i_cmd,
    output gdo_pkg::t_stat                    o_stat,
    input  logic [4:0]                        i_day,
    input  logic [3:0]                        i_month,
    input  logic [13:0]                       i_year,
    input  logic signed [gdo_pkg::OFFSET_BITS-1:0] i_day_offset,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [4:0]                        o_day,
    output logic [3:0]                        o_month,
    output logic [13:0]                       o_year,
    output logic [2:0]                        o_weekday,
    output logic [1:0]                        o_status
);
    localparam int SB = gdo_pkg::SUM_BITS;
    localparam int AB = gdo_pkg::ACC_BITS;

    logic [4:0]            r_org_d;
    logic [3:0]            r_org_m;
    logic [13:0]           r_org_y;
    logic [4:0]            r_d;
    logic [3:0]            r_m;
    logic [13:0]           r_y;
    logic [13:0]           r_yrem;
    logic signed [SB-1:0]  r_rem;
    gdo_pkg::t_status      r_status;
    logic [AB-1:0]         r_acc;
    logic                  r_o_valid;
    logic [4:0]            r_o_day;
    logic [3:0]            r_o_month;
    logic [13:0]           r_o_year;
    logic [2:0]            r_o_weekday;
    logic [1:0]            r_o_status;

    logic                  w_leap;
    logic [4:0]            w_dim;
    logic [4:0]            w_gap;
    logic [3:0]            w_prev_m;
    logic [4:0]            w_prev_dim;
    logic signed [SB-1:0]  w_gap_s;
    logic signed [SB-1:0]  w_d_s;
    logic                  w_pos;
    logic                  w_neg;
    logic                  w_fwd_jump;
    logic                  w_back_jump;
    logic [13:0]           w_div;
    logic [AB-1:0]         w_m7;
    logic [AB-1:0]         w_yp;
    logic [AB-1:0]         w_yy;
    logic                  w_early;
    logic [4:0]            w_cent;
    logic [2:0]            w_quad;
    logic [AB-1:0]         w_sum;

    always_comb begin
        w_leap      = gdo_pkg::is_leap(r_yrem[8:0]);
        w_dim       = gdo_pkg::days_in_month(r_m, w_leap);
        w_gap       = w_dim - r_d;
        w_prev_m    = (r_m == 4'd1) ? 4'd12 : r_m - 4'd1;
        w_prev_dim  = gdo_pkg::days_in_month(w_prev_m, w_leap);
        w_gap_s     = signed'({{(SB-5){1'b0}}, w_gap});
        w_d_s       = signed'({{(SB-5){1'b0}}, r_d});
        w_neg       = r_rem[SB-1];
        w_pos       = !w_neg && (r_rem != '0);
        w_fwd_jump  = w_pos && (r_rem > w_gap_s);
        w_back_jump = w_neg && ((r_rem + w_d_s) <= signed'(SB'(0)));
        w_div       = 14'd400 << i_cmd.step;
        w_m7        = 12'd7 << i_cmd.step;

        // weekday depends on year mod 400 only; evaluate at 2000 + (y mod 400)
        w_yp    = 12'd2000 + {3'd0, r_yrem[8:0]};
        w_early = r_m < 4'd3;
        w_yy    = w_early ? w_yp - 12'd1 : w_yp;
        if (w_yy >= 12'd2300) begin
            w_cent = 5'd23;
        end else if (w_yy >= 12'd2200) begin
            w_cent = 5'd22;
        end else if (w_yy >= 12'd2100) begin
            w_cent = 5'd21;
        end else if (w_yy >= 12'd2000) begin
            w_cent = 5'd20;
        end else begin
            w_cent = 5'd19;
        end
        w_quad = (w_yy >= 12'd2000) ? 3'd5 : 3'd4;
        w_sum  = {7'd0, gdo_pkg::month_term(r_m)} + {7'd0, r_d} + w_yp + 12'd4
                 + {2'd0, w_yy[11:2]} + {9'd0, w_quad} - {7'd0, w_cent}
                 - (w_early ? 12'd0 : 12'd2);
    end

    always_comb begin
        o_stat.bad_date  = (r_y < gdo_pkg::BASE_YEAR) || (r_m == 4'd0) || (r_m > 4'd12)
                           || (r_d == 5'd0) || (r_d > w_dim);
        o_stat.fwd_high  = (r_y > gdo_pkg::LAST_YEAR) && !w_neg;
        o_stat.walk_done = (r_rem == '0);
        o_stat.walk_fail = (w_fwd_jump && (r_m == 4'd12) && (r_y >= gdo_pkg::LAST_YEAR))
                           || (w_back_jump && (r_m == 4'd1) && (r_y <= gdo_pkg::BASE_YEAR));
        o_stat.year_high = r_y > gdo_pkg::LAST_YEAR;
        o_stat.out_busy  = r_o_valid && !i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            gdo_pkg::OP_LOAD: begin
                r_org_d  <= i_day;
                r_org_m  <= i_month;
                r_org_y  <= i_year;
                r_d      <= i_day;
                r_m      <= i_month;
                r_y      <= i_year;
                r_yrem   <= i_year;
                r_rem    <= {{(SB-gdo_pkg::OFFSET_BITS){i_day_offset[gdo_pkg::OFFSET_BITS-1]}},
                             i_day_offset};
                r_status <= gdo_pkg::STATUS_OK;
            end
            gdo_pkg::OP_REDUCE: begin
                if (r_yrem >= w_div) begin
                    r_yrem <= r_yrem - w_div;
                end
            end
            gdo_pkg::OP_MARK_BAD:   r_status <= gdo_pkg::STATUS_BAD_DATE;
            gdo_pkg::OP_MARK_RANGE: r_status <= gdo_pkg::STATUS_RANGE;
            gdo_pkg::OP_WALK: begin
                if (w_fwd_jump) begin
                    r_rem <= r_rem - w_gap_s - signed'(SB'(1));
                    r_d   <= 5'd1;
                    if (r_m == 4'd12) begin
                        r_m    <= 4'd1;
                        r_y    <= r_y + 14'd1;
                        r_yrem <= (r_yrem == 14'd399) ? 14'd0 : r_yrem + 14'd1;
                    end else begin
                        r_m <= r_m + 4'd1;
                    end
                end else if (w_back_jump) begin
                    r_rem <= r_rem + w_d_s;
                    r_d   <= w_prev_dim;
                    r_m   <= w_prev_m;
                    if (r_m == 4'd1) begin
                        r_y    <= r_y - 14'd1;
                        r_yrem <= (r_yrem == 14'd0) ? 14'd399 : r_yrem - 14'd1;
                    end
                end else begin
                    r_d   <= r_d + r_rem[4:0];
                    r_rem <= '0;
                end
            end
            gdo_pkg::OP_WDAY: r_acc <= w_sum;
            gdo_pkg::OP_MOD7: begin
                if (r_acc >= w_m7) begin
                    r_acc <= r_acc - w_m7;
                end
            end
            gdo_pkg::OP_EMIT: begin
                r_o_status <= r_status;
                if (r_status == gdo_pkg::STATUS_OK) begin
                    r_o_day     <= r_d;
                    r_o_month   <= r_m;
                    r_o_year    <= r_y;
                    r_o_weekday <= r_acc[2:0];
                end else begin
                    r_o_day     <= r_org_d;
                    r_o_month   <= r_org_m;
                    r_o_year    <= r_org_y;
                    r_o_weekday <= 3'd0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.op == gdo_pkg::OP_EMIT) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_day       = r_o_day;
    assign o_month     = r_o_month;
    assign o_year      = r_o_year;
    assign o_weekday   = r_o_weekday;
    assign o_status    = r_o_status;

endmodule

@@ sv/gdo_ctrl.sv @@
// gdo_ctrl: sequencer for one beat: load, year reduction, date check, walk,
// weekday reduction, hand-off to the output register. Depends on gdo_pkg.
module gdo_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  gdo_pkg::t_stat i_stat,
    output gdo_pkg::t_cmd  o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_CHECK,
        S_WALK,
        S_WDAY,
        S_MOD7,
        S_DONE
    } t_state;

    localparam logic [gdo_pkg::STEP_BITS-1:0] CNT_ONE = {{(gdo_pkg::STEP_BITS-1){1'b0}}, 1'b1};

    t_state                        r_state;
    t_state                        n_state;
    logic [gdo_pkg::STEP_BITS-1:0] r_cnt;
    logic [gdo_pkg::STEP_BITS-1:0] n_cnt;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd.op   = gdo_pkg::OP_NONE;
        o_cmd.step = r_cnt;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = gdo_pkg::OP_LOAD;
                    n_cnt    = gdo_pkg::REDUCE_TOP;
                    n_state  = S_REDUCE;
                end
            end
            S_REDUCE: begin
                o_cmd.op = gdo_pkg::OP_REDUCE;
                n_cnt    = r_cnt - CNT_ONE;
                if (r_cnt == '0) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.bad_date) begin
                    o_cmd.op = gdo_pkg::OP_MARK_BAD;
                    n_state  = S_DONE;
                end else if (i_stat.fwd_high) begin
                    o_cmd.op = gdo_pkg::OP_MARK_RANGE;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (i_stat.walk_fail) begin
                    o_cmd.op = gdo_pkg::OP_MARK_RANGE;
                    n_state  = S_DONE;
                end else if (i_stat.walk_done) begin
                    if (i_stat.year_high) begin
                        o_cmd.op = gdo_pkg::OP_MARK_RANGE;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_WDAY;
                    end
                end else begin
                    o_cmd.op = gdo_pkg::OP_WALK;
                end
            end
            S_WDAY: begin
                o_cmd.op = gdo_pkg::OP_WDAY;
                n_cnt    = gdo_pkg::MOD7_TOP;
                n_state  = S_MOD7;
            end
            S_MOD7: begin
                o_cmd.op = gdo_pkg::OP_MOD7;
                n_cnt    = r_cnt - CNT_ONE;
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op = gdo_pkg::OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

@@ test/tb_gregorian_date_offset.sv @@
`timescale 1ns / 100ps
// tb_gregorian_date_offset: self-checking bench for the date offset block.
// Needs gdo_pkg, gdo_in_if, gdo_out_if and gregorian_date_offset; a calendar
// predictor checks every result beat, with random idling on both channels.
module tb_gregorian_date_offset;

    localparam int RESET_CYCLES    = 6;
    localparam int RANDOM_ITEMS    = 500;
    localparam int HOLD_OFF_CYCLES = 1500;
    localparam int WATCHDOG_LIMIT  = 12000;
    localparam int TAIL_CYCLES     = 64;
    localparam int FIRST_YEAR      = 1601;
    localparam int END_YEAR        = 10000;

    typedef logic signed [gdo_pkg::OFFSET_BITS-1:0] offset_t;

    typedef struct {
        logic [4:0]                             day;
        logic [3:0]                             month;
        logic [13:0]                            year;
        offset_t                                offset;
        bit                                     drain_first;
    } date_query_t;

    typedef struct {
        logic [4:0]       day;
        logic [3:0]       month;
        logic [13:0]      year;
        logic [2:0]       wday;
        gdo_pkg::t_status status;
    } date_result_t;

    logic i_clk;
    logic i_rst_n;

    gdo_in_if  in_ch ();
    gdo_out_if out_ch ();

    gregorian_date_offset dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    date_query_t  pending_items[$];
    date_result_t expected_dates[$];
    date_query_t  offered;
    int           total_items;
    int           sent_beats;
    int           got_beats;
    int           error_count;
    int           send_gap;
    int           sink_gap;
    int           quiet_cycles;

    function automatic bit leap_year(int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int month_length(int m, int y);
        if (m == 2) return leap_year(y) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
        return 31;
    endfunction

    // days from the first of January of the base year
    function automatic int days_to_year(int y);
        int k;
        k = y - FIRST_YEAR;
        return 365 * k + k / 4 - k / 100 + k / 400;
    endfunction

    function automatic int weekday_from_date(int d, int m, int y);
        int dd;
        int yy;
        if (m < 3) begin
            dd = d + y;
            yy = y - 1;
        end else begin
            dd = d + y - 2;
            yy = y;
        end
        return (23 * m / 9 + dd + 4 + yy / 4 - yy / 100 + yy / 400) % 7;
    endfunction

    function automatic date_result_t shift_date(date_query_t q);
        date_result_t r;
        int d;
        int m;
        int y;
        int n;
        int i;
        int rm;
        int ry;
        d = int'(q.day);
        m = int'(q.month);
        y = int'(q.year);
        r.day = q.day;
        r.month = q.month;
        r.year = q.year;
        r.wday = '0;
        r.status = gdo_pkg::STATUS_OK;
        if (y < FIRST_YEAR || m < 1 || m > 12 || d < 1 || d > month_length(m, y)) begin
            r.status = gdo_pkg::STATUS_BAD_DATE;
            return r;
        end
        n = days_to_year(y) + d - 1;
        for (i = 1; i < m; i++) n += month_length(i, y);
        n += int'(q.offset);
        if (n < 0 || n >= days_to_year(END_YEAR)) begin
            r.status = gdo_pkg::STATUS_RANGE;
            return r;
        end
        ry = FIRST_YEAR + n / 366;
        while (days_to_year(ry + 1) <= n) ry++;
        n -= days_to_year(ry);
        rm = 1;
        while (n >= month_length(rm, ry)) begin
            n -= month_length(rm, ry);
            rm++;
        end
        r.day = 5'(n + 1);
        r.month = 4'(rm);
        r.year = 14'(ry);
        r.wday = 3'(weekday_from_date(n + 1, rm, ry));
        return r;
    endfunction

    function automatic date_query_t random_date(int ylo, int yhi);
        date_query_t q;
        q.year = 14'($urandom_range(yhi, ylo));
        q.month = 4'($urandom_range(12, 1));
        q.day = 5'($urandom_range(month_length(int'(q.month), int'(q.year)), 1));
        q.offset = '0;
        q.drain_first = 1'b0;
        return q;
    endfunction

    // long zero-gap stretches, otherwise mostly short gaps and a few long ones
    function automatic int idle_cycles(int beats);
        int r;
        if (beats % 128 < 32) return 0;
        r = $urandom_range(99, 0);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(60, 12);
    endfunction

    task automatic queue_date(input int d, input int m, input int y, input int off);
        date_query_t q;
        q.day = 5'(d);
        q.month = 4'(m);
        q.year = 14'(y);
        q.offset = offset_t'(off);
        q.drain_first = 1'b0;
        pending_items.push_back(q);
    endtask

    task automatic note_mismatch(input string msg);
        error_count++;
        if (error_count <= 10) $display("%s", msg);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            sent_beats <= 0;
            send_gap = 0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid) begin
                expected_dates.push_back(shift_date(offered));
                sent_beats <= sent_beats + 1;
                send_gap = idle_cycles(sent_beats);
            end
            if (send_gap != 0) begin
                send_gap = send_gap - 1;
                in_ch.valid <= 1'b0;
            end else if (pending_items.size() != 0 && !(pending_items[0].drain_first &&
                         (in_ch.valid || sent_beats != got_beats))) begin
                offered = pending_items.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.in_day <= offered.day;
                in_ch.in_month <= offered.month;
                in_ch.in_year <= offered.year;
                in_ch.day_offset <= offered.offset;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        date_result_t want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            got_beats <= 0;
            sink_gap = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got_beats <= got_beats + 1;
                if (expected_dates.size() == 0) begin
                    note_mismatch($sformatf("unexpected beat: %0d-%0d-%0d wday %0d status %0d",
                        out_ch.out_year, out_ch.out_month, out_ch.out_day, out_ch.weekday,
                        out_ch.status));
                end else begin
                    want = expected_dates.pop_front();
                    if (out_ch.out_day !== want.day || out_ch.out_month !== want.month ||
                        out_ch.out_year !== want.year || out_ch.weekday !== want.wday ||
                        out_ch.status !== want.status) begin
                        note_mismatch($sformatf(
                            "beat %0d: exp %0d-%0d-%0d wday %0d status %0d, got %0d-%0d-%0d wday %0d status %0d",
                            got_beats, want.year, want.month, want.day, want.wday, want.status,
                            out_ch.out_year, out_ch.out_month, out_ch.out_day, out_ch.weekday,
                            out_ch.status));
                    end
                end
                if (got_beats == 40 || got_beats == 300) sink_gap = HOLD_OFF_CYCLES;
                else sink_gap = idle_cycles(got_beats);
            end
            if (sink_gap != 0) begin
                sink_gap = sink_gap - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_gregorian_date_offset: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        date_query_t q;
        int          kind;
        int          i;
        int          mlen;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.in_day = '0;
        in_ch.in_month = '0;
        in_ch.in_year = '0;
        in_ch.day_offset = '0;
        out_ch.ready = 1'b0;
        error_count = 0;
        quiet_cycles = 0;

        // leap days, month and year edges, bad dates, range edges
        queue_date(29, 2, 2000, 0);
        queue_date(29, 2, 1900, 5);
        queue_date(29, 2, 2004, 365);
        queue_date(0, 5, 2000, 1);
        queue_date(31, 4, 2000, 1);
        queue_date(31, 1, 2000, 1);
        queue_date(10, 0, 2000, 1);
        queue_date(10, 13, 2000, 1);
        queue_date(31, 15, 16383, -1);
        queue_date(1, 1, 0, 0);
        queue_date(31, 12, 1600, 1);
        queue_date(1, 1, 1601, 0);
        queue_date(1, 1, 1601, -1);
        queue_date(31, 12, 9999, 0);
        queue_date(31, 12, 9999, 1);
        queue_date(1, 1, 1601, 32767);
        queue_date(31, 12, 9999, -32768);
        queue_date(15, 6, 2000, 32767);
        queue_date(15, 6, 2000, -32768);
        queue_date(1, 1, 10050, -32768);
        queue_date(1, 1, 10000, 0);
        queue_date(31, 12, 16383, -32768);
        queue_date(1, 3, 1700, -1);
        queue_date(1, 3, 2000, -1);
        queue_date(31, 12, 1999, 1);

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            kind = $urandom_range(99, 0);
            if (kind < 12) begin
                q.day = 5'($urandom);
                q.month = 4'($urandom);
                q.year = 14'($urandom);
                q.offset = offset_t'($urandom);
            end else if (kind < 20) begin
                q = random_date(FIRST_YEAR, 9999);
                q.offset = offset_t'(int'($urandom_range(200, 0)) - 100);
                mlen = month_length(int'(q.month), int'(q.year));
                case ($urandom_range(2, 0))
                    0: q.day = (mlen == 31) ? 5'd0 : 5'($urandom_range(31, mlen + 1));
                    1: q.month = ($urandom_range(3, 0) == 0) ? 4'd0 :
                                 4'($urandom_range(15, 13));
                    default: q.year = 14'($urandom_range(FIRST_YEAR - 1, 0));
                endcase
            end else if (kind < 35) begin
                if ($urandom_range(1, 0) != 0) begin
                    q = random_date(FIRST_YEAR, 1700);
                    q.offset = offset_t'(-int'($urandom_range(32768, 0)));
                end else begin
                    q = random_date(9900, 9999);
                    q.offset = offset_t'($urandom_range(32767, 0));
                end
            end else if (kind < 45) begin
                q = random_date(FIRST_YEAR, 16383);
                q.offset = offset_t'($urandom);
            end else begin
                q = random_date(FIRST_YEAR, 9999);
                q.offset = offset_t'(int'($urandom_range(1600, 0)) - 800);
            end
            q.drain_first = (i == 0 || i == RANDOM_ITEMS / 2);
            pending_items.push_back(q);
        end
        total_items = pending_items.size();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (got_beats < total_items) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_dates.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", expected_dates.size()));

        if (error_count == 0) begin
            $display("tb_gregorian_date_offset: PASS");
        end else begin
            $display("tb_gregorian_date_offset: FAIL");
        end
        $finish;
    end

endmodule
